[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define TCCE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcce assertion failed");

// clocked assertion that also holds during reset
`define TCCE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("tcce reset assertion failed");

`endif

[rtl/tcce_pkg.sv]
// types, codes and constants of the text console cursor engine
`timescale 1ns / 1ps

package tcce_pkg;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_SET_POS = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_DRAW         = 2'd0,
    ACT_CLEAR_CELL   = 2'd1,
    ACT_SCROLL       = 2'd2,
    ACT_CLEAR_SCREEN = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_TEXT_COLUMNS = 2'd0,
    CFG_ROW_COUNT    = 2'd1,
    CFG_FG_INDEX     = 2'd2,
    CFG_BG_INDEX     = 2'd3
  } cfg_index_e;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_LINE_FEED = 8'd10;
  localparam logic [7:0] CH_CARRIAGE  = 8'd13;
  localparam logic [7:0] CH_FIRST_PRT = 8'd32;
  localparam logic [7:0] CH_LAST_PRT  = 8'd126;

  localparam logic [7:0] COLUMNS_RESET = 8'd128;
  localparam logic [7:0] ROWS_RESET    = 8'd48;
  localparam logic [3:0] FG_RESET      = 4'd15;
  localparam logic [3:0] BG_RESET      = 4'd0;

  localparam logic [31:0] RGB_MASK = 32'h00FF_FFFF;

  localparam logic [31:0] PALETTE [16] = '{
    32'hFF00_0000, 32'hFF00_00AA, 32'hFF00_AA00, 32'hFF00_AAAA,
    32'hFFAA_0000, 32'hFFAA_00AA, 32'hFFAA_5500, 32'hFFAA_AAAA,
    32'hFF55_5555, 32'hFF55_55FF, 32'hFF55_FF55, 32'hFF55_FFFF,
    32'hFFFF_5555, 32'hFFFF_55FF, 32'hFFFF_FF55, 32'hFFFF_FFFF
  };

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] char_code;
    logic [7:0] new_column;
    logic [7:0] new_row;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [6:0]  glyph_code;
    logic [31:0] pixel_color;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0] text_columns;
    logic [7:0] row_count;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
  } cfg_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
  } cursor_t;

  typedef struct packed {
    logic [1:0] count;
    cursor_t    cursor;
    out_item_t  first;
    out_item_t  second;
  } step_t;

endpackage

[rtl/tcce_step.sv]
// command decode: next cursor and up to two result items for one input item
`timescale 1ns / 1ps

module tcce_step import tcce_pkg::*; (
  input  in_item_t item_i,
  input  cursor_t  cursor_i,
  input  cfg_t     cfg_i,
  output step_t    step_o
);

  function automatic out_item_t make_item(action_e act, logic [7:0] col, logic [7:0] row,
                                          logic [6:0] glyph, logic [31:0] color,
                                          logic last);
    out_item_t r;
    r.action      = act;
    r.cell_column = col;
    r.cell_row    = row;
    r.glyph_code  = glyph;
    r.pixel_color = color;
    r.last_result = last;
    return r;
  endfunction

  logic [7:0]  eff_cols;
  logic [7:0]  eff_rows;
  logic [31:0] bg_word;
  logic [31:0] fg_rgb;
  logic [8:0]  row_inc;
  logic        lf_scroll;
  logic [7:0]  lf_row;
  logic        wrap;
  logic        wrap_scroll;
  logic        printable;
  logic [7:0]  draw_col;
  logic [7:0]  draw_row;
  out_item_t   draw_item;

  always_comb begin
    eff_cols    = (cfg_i.text_columns == 8'd0) ? 8'd1 : cfg_i.text_columns;
    eff_rows    = (cfg_i.row_count == 8'd0) ? 8'd1 : cfg_i.row_count;
    bg_word     = PALETTE[cfg_i.bg_index];
    fg_rgb      = PALETTE[cfg_i.fg_index] & RGB_MASK;
    row_inc     = {1'b0, cursor_i.row} + 9'd1;
    lf_scroll   = row_inc >= {1'b0, eff_rows};
    lf_row      = lf_scroll ? (eff_rows - 8'd1) : row_inc[7:0];
    wrap        = cursor_i.column >= eff_cols;
    wrap_scroll = wrap && lf_scroll;
    printable   = item_i.char_code <= CH_LAST_PRT;
    draw_col    = wrap ? 8'd0 : cursor_i.column;
    draw_row    = wrap ? lf_row : cursor_i.row;
    draw_item   = make_item(ACT_DRAW, draw_col, draw_row, item_i.char_code[6:0], fg_rgb,
                            1'b1);

    step_o        = '0;
    step_o.cursor = cursor_i;

    case (item_i.opcode)
      OP_SET_POS: begin
        if (item_i.new_column < eff_cols) begin
          step_o.cursor.column = item_i.new_column;
        end
        if (item_i.new_row < eff_rows) begin
          step_o.cursor.row = item_i.new_row;
        end
      end
      OP_CLEAR: begin
        step_o.count  = 2'd1;
        step_o.first  = make_item(ACT_CLEAR_SCREEN, 8'd0, 8'd0, 7'd0, 32'd0, 1'b1);
        step_o.cursor = '0;
      end
      OP_PUT: begin
        if (item_i.char_code == CH_LINE_FEED) begin
          step_o.cursor.column = 8'd0;
          step_o.cursor.row    = lf_row;
          if (lf_scroll) begin
            step_o.count = 2'd1;
            step_o.first = make_item(ACT_SCROLL, 8'd0, 8'd0, 7'd0, bg_word, 1'b1);
          end
        end else if (item_i.char_code == CH_CARRIAGE) begin
          step_o.cursor.column = 8'd0;
        end else if (item_i.char_code == CH_BACKSPACE) begin
          if (cursor_i.column != 8'd0) begin
            step_o.cursor.column = cursor_i.column - 8'd1;
            step_o.count = 2'd1;
            step_o.first = make_item(ACT_CLEAR_CELL, cursor_i.column - 8'd1, cursor_i.row,
                                     7'd0, bg_word, 1'b1);
          end
        end else if (item_i.char_code >= CH_FIRST_PRT) begin
          step_o.cursor.column = draw_col + 8'd1;
          step_o.cursor.row    = draw_row;
          if (wrap_scroll && printable) begin
            step_o.count  = 2'd2;
            step_o.first  = make_item(ACT_SCROLL, 8'd0, 8'd0, 7'd0, bg_word, 1'b0);
            step_o.second = draw_item;
          end else if (wrap_scroll) begin
            step_o.count = 2'd1;
            step_o.first = make_item(ACT_SCROLL, 8'd0, 8'd0, 7'd0, bg_word, 1'b1);
          end else if (printable) begin
            step_o.count = 2'd1;
            step_o.first = draw_item;
          end
        end
      end
      default: begin
        step_o.count = 2'd0;
      end
    endcase
  end

endmodule

[rtl/tcce_outq.sv]
// four-entry result queue: up to two in per cycle, one out if ready
`timescale 1ns / 1ps

module tcce_outq import tcce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] push_cnt_i,
  input  out_item_t first_i,
  input  out_item_t second_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  out_item_t  entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = count_q != 3'd0;
  assign out_item_o  = entry_q[rd_ptr_q];
  assign room_o      = count_q <= 3'd2;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_cnt_i} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= first_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= second_i;
    end
  end

endmodule

[rtl/text_console_cursor_engine.sv]
// top level of the text console cursor engine
`timescale 1ns / 1ps

// Takes one console command item per cycle while ready and turns it into zero,
// one or two cell command items, written to the result queue when the command
// is accepted. The cursor state is updated at the same clock edge, so
// commands can follow back to back. Results drain through a four-entry queue
// at one item per cycle while out_ready_i is high; the input is ready while
// at least two queue slots are free, so both items of a command that causes a
// scroll and a draw always fit. Register writes take effect at the next clock edge.
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  cfg_index_e cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  cursor_t    cursor_q, cursor_d;
  step_t      step;
  logic       room;
  logic       accept;
  logic [1:0] push_cnt;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;
  assign push_cnt   = accept ? step.count : 2'd0;

  tcce_step u_step (
    .item_i   (in_item_i),
    .cursor_i (cursor_q),
    .cfg_i    (cfg_q),
    .step_o   (step)
  );

  tcce_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .first_i     (step.first),
    .second_i    (step.second),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always_comb begin
    cfg_d    = cfg_q;
    cursor_d = accept ? step.cursor : cursor_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TEXT_COLUMNS: cfg_d.text_columns = cfg_data_i;
        CFG_ROW_COUNT:    cfg_d.row_count    = cfg_data_i;
        CFG_FG_INDEX:     cfg_d.fg_index     = cfg_data_i[3:0];
        CFG_BG_INDEX:     cfg_d.bg_index     = cfg_data_i[3:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_columns <= COLUMNS_RESET;
      cfg_q.row_count    <= ROWS_RESET;
      cfg_q.fg_index     <= FG_RESET;
      cfg_q.bg_index     <= BG_RESET;
      cursor_q           <= '0;
    end else begin
      cfg_q    <= cfg_d;
      cursor_q <= cursor_d;
    end
  end

endmodule

[rtl/tcce_checker.sv]
// port-level checks of the text console cursor engine, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcce_checker import tcce_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input in_item_t   in_item_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_item_t  out_item_o
);

  logic in_acc;
  logic clr_acc;
  logic pos_acc;
  logic clr_shown;

  assign in_acc    = in_valid_i && in_ready_o;
  assign clr_acc   = in_acc && in_item_i.opcode == OP_CLEAR && !out_valid_o;
  assign pos_acc   = in_acc && in_item_i.opcode == OP_SET_POS && !out_valid_o;
  assign clr_shown = out_valid_o && out_item_o.action == ACT_CLEAR_SCREEN &&
                     out_item_o.last_result && out_item_o.pixel_color == 32'd0;

  `TCCE_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_o && in_ready_o)
  `TCCE_ASSERT(a_clear_result, clr_acc |=> clr_shown)
  `TCCE_ASSERT(a_set_pos_silent, pos_acc |=> !out_valid_o)
  `TCCE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);

[test/text_console_cursor_engine_tb.sv]
// self-checking testbench for the text console cursor engine
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES = 9;
  localparam int QUIET_LIMIT = 2000;

  localparam logic [7:0] PH_COLS [NUM_PHASES] = '{128, 1, 255, 0, 3, 80, 40, 7, 128};
  localparam logic [7:0] PH_ROWS [NUM_PHASES] = '{48, 1, 255, 0, 2, 25, 1, 255, 48};
  localparam logic [3:0] PH_FG   [NUM_PHASES] = '{15, 0, 7, 15, 3, 9, 12, 6, 15};
  localparam logic [3:0] PH_BG   [NUM_PHASES] = '{0, 15, 8, 0, 5, 1, 14, 10, 0};

  typedef struct {
    in_item_t  cmd;
    bit        lit;
    out_item_t exp_item;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_item_o;
  logic       cfg_we_i;
  cfg_index_e cfg_index_i;
  logic [7:0] cfg_data_i;

  logic [7:0] cfg_cols = COLUMNS_RESET;
  logic [7:0] cfg_rows = ROWS_RESET;
  logic [3:0] cfg_fg = FG_RESET;
  logic [3:0] cfg_bg = BG_RESET;
  logic [7:0] cur_col = '0;
  logic [7:0] cur_row = '0;

  out_item_t expected_cells[$];
  stim_row_t stim_rows[$];
  bit        lit_use;
  out_item_t lit_cell;
  bit        idle_on;
  int        fail_count;
  int        quiet_cycles;

  text_console_cursor_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int eff_count(logic [7:0] v);
    return (v == 8'd0) ? 1 : int'(v);
  endfunction

  function automatic out_item_t make_cell(action_e act, logic [7:0] col, logic [7:0] row,
                                          logic [6:0] glyph, logic [31:0] color, logic last);
    out_item_t r;
    r.action      = act;
    r.cell_column = col;
    r.cell_row    = row;
    r.glyph_code  = glyph;
    r.pixel_color = color;
    r.last_result = last;
    return r;
  endfunction

  // column to zero, row down one; returns 1 when the screen scrolls
  function automatic bit drop_line();
    cur_col = '0;
    if (int'(cur_row) + 1 >= eff_count(cfg_rows)) begin
      cur_row = 8'(eff_count(cfg_rows) - 1);
      return 1'b1;
    end
    cur_row = cur_row + 8'd1;
    return 1'b0;
  endfunction

  function automatic int predict_cells(input in_item_t c, output out_item_t r0,
                                       output out_item_t r1);
    out_item_t res [2];
    int n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    case (c.opcode)
      OP_SET_POS: begin
        if (int'(c.new_column) < eff_count(cfg_cols)) cur_col = c.new_column;
        if (int'(c.new_row) < eff_count(cfg_rows)) cur_row = c.new_row;
      end
      OP_CLEAR: begin
        res[0] = make_cell(ACT_CLEAR_SCREEN, 8'd0, 8'd0, 7'd0, 32'd0, 1'b0);
        n = 1;
        cur_col = '0;
        cur_row = '0;
      end
      OP_PUT: begin
        if (c.char_code == CH_LINE_FEED) begin
          if (drop_line()) begin
            res[n] = make_cell(ACT_SCROLL, 8'd0, 8'd0, 7'd0, PALETTE[cfg_bg], 1'b0);
            n++;
          end
        end else if (c.char_code == CH_CARRIAGE) begin
          cur_col = '0;
        end else if (c.char_code == CH_BACKSPACE) begin
          if (cur_col != 8'd0) begin
            cur_col = cur_col - 8'd1;
            res[n] = make_cell(ACT_CLEAR_CELL, cur_col, cur_row, 7'd0, PALETTE[cfg_bg], 1'b0);
            n++;
          end
        end else if (c.char_code >= CH_FIRST_PRT) begin
          if (int'(cur_col) >= eff_count(cfg_cols)) begin
            if (drop_line()) begin
              res[n] = make_cell(ACT_SCROLL, 8'd0, 8'd0, 7'd0, PALETTE[cfg_bg], 1'b0);
              n++;
            end
          end
          if (c.char_code <= CH_LAST_PRT) begin
            res[n] = make_cell(ACT_DRAW, cur_col, cur_row, c.char_code[6:0],
                               PALETTE[cfg_fg] & RGB_MASK, 1'b0);
            n++;
          end
          cur_col = cur_col + 8'd1;
        end
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last_result = 1'b1;
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i = idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t r0;
    out_item_t r1;
    int n;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_cells.size() == 0) begin
          $error("unexpected result item action %0d", out_item_o.action);
          fail_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_item_o.action !== want.action) begin
            $error("action expected %0d got %0d", want.action, out_item_o.action);
            fail_count++;
          end
          if (out_item_o.cell_column !== want.cell_column) begin
            $error("cell_column expected %0d got %0d", want.cell_column, out_item_o.cell_column);
            fail_count++;
          end
          if (out_item_o.cell_row !== want.cell_row) begin
            $error("cell_row expected %0d got %0d", want.cell_row, out_item_o.cell_row);
            fail_count++;
          end
          if (out_item_o.glyph_code !== want.glyph_code) begin
            $error("glyph_code expected %0h got %0h", want.glyph_code, out_item_o.glyph_code);
            fail_count++;
          end
          if (out_item_o.pixel_color !== want.pixel_color) begin
            $error("pixel_color expected %08h got %08h", want.pixel_color,
                   out_item_o.pixel_color);
            fail_count++;
          end
          if (out_item_o.last_result !== want.last_result) begin
            $error("last_result expected %0d got %0d", want.last_result, out_item_o.last_result);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TEXT_COLUMNS: cfg_cols = cfg_data_i;
          CFG_ROW_COUNT:    cfg_rows = cfg_data_i;
          CFG_FG_INDEX:     cfg_fg = cfg_data_i[3:0];
          CFG_BG_INDEX:     cfg_bg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        n = predict_cells(in_item_i, r0, r1);
        if (lit_use) begin
          expected_cells.push_back(lit_cell);
        end else begin
          if (n > 0) expected_cells.push_back(r0);
          if (n > 1) expected_cells.push_back(r1);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_row(logic [1:0] op, logic [7:0] ch, logic [7:0] col, logic [7:0] row,
                         bit lit, out_item_t exp_item);
    stim_row_t r;
    r.cmd.opcode     = opcode_e'(op);
    r.cmd.char_code  = ch;
    r.cmd.new_column = col;
    r.cmd.new_row    = row;
    r.lit            = lit;
    r.exp_item       = exp_item;
    stim_rows.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_cmd(in_item_t cmd, bit lit, out_item_t exp_item);
    in_valid_i = 1'b0;
    while (idle_on && $urandom_range(99) < 25) begin
      in_item_i.char_code = 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = cmd;
    lit_use    = lit;
    lit_cell   = exp_item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(cfg_index_e idx, logic [7:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_cells.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    in_item_t cmd;
    int pick;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_TEXT_COLUMNS;
    cfg_data_i   = '0;
    lit_use      = 1'b0;
    lit_cell     = '0;
    idle_on      = 1'b1;
    fail_count   = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(OP_CLEAR, 8'h00, 8'h00, 8'h00, 1,
            make_cell(ACT_CLEAR_SCREEN, 8'd0, 8'd0, 7'd0, 32'd0, 1'b1));
    add_row(OP_PUT, 8'h41, 8'h00, 8'h00, 1,
            make_cell(ACT_DRAW, 8'd0, 8'd0, 7'h41, 32'h00FF_FFFF, 1'b1));
    add_row(OP_PUT, CH_LAST_PRT, 8'hFF, 8'hFF, 1,
            make_cell(ACT_DRAW, 8'd1, 8'd0, 7'h7E, 32'h00FF_FFFF, 1'b1));
    add_row(OP_PUT, CH_FIRST_PRT, 8'h00, 8'h00, 1,
            make_cell(ACT_DRAW, 8'd2, 8'd0, 7'h20, 32'h00FF_FFFF, 1'b1));
    add_row(OP_PUT, 8'd127, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, 8'd255, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, CH_BACKSPACE, 8'h00, 8'h00, 1,
            make_cell(ACT_CLEAR_CELL, 8'd4, 8'd0, 7'd0, 32'hFF00_0000, 1'b1));
    add_row(OP_PUT, CH_CARRIAGE, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, CH_BACKSPACE, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, 8'd0, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, 8'd31, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, 8'd7, 8'h00, 8'h00, 0, '0);
    add_row(OP_SET_POS, 8'h00, 8'd127, 8'd47, 0, '0);
    add_row(OP_PUT, 8'h5A, 8'h00, 8'h00, 0, '0);
    add_row(OP_PUT, 8'h59, 8'h00, 8'h00, 0, '0);
    add_row(OP_SET_POS, 8'hFF, 8'd255, 8'd255, 0, '0);
    add_row(OP_SET_POS, 8'h00, 8'd128, 8'd48, 0, '0);
    add_row(OP_SET_POS, 8'h00, 8'd0, 8'd255, 0, '0);
    add_row(OP_PUT, CH_LINE_FEED, 8'h00, 8'h00, 0, '0);
    add_row(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 0, '0);
    add_row(OP_SET_POS, 8'h00, 8'd5, 8'd10, 0, '0);
    add_row(OP_PUT, CH_LINE_FEED, 8'hFF, 8'hFF, 0, '0);
    add_row(OP_PUT, 8'h61, 8'hFF, 8'hFF, 0, '0);
    add_row(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1,
            make_cell(ACT_CLEAR_SCREEN, 8'd0, 8'd0, 7'd0, 32'd0, 1'b1));

    foreach (stim_rows[i]) send_cmd(stim_rows[i].cmd, stim_rows[i].lit, stim_rows[i].exp_item);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_TEXT_COLUMNS, PH_COLS[ph]);
      write_reg(CFG_ROW_COUNT, PH_ROWS[ph]);
      write_reg(CFG_FG_INDEX, {4'($urandom), PH_FG[ph]});
      write_reg(CFG_BG_INDEX, {4'($urandom), PH_BG[ph]});
      @(negedge clk_i);
      idle_on = (ph != 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        cmd.opcode     = OP_PUT;
        cmd.char_code  = 8'($urandom);
        cmd.new_column = 8'($urandom);
        cmd.new_row    = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
          cmd.char_code = 8'($urandom_range(32, 126));
        end else if (pick < 65) begin
          cmd.char_code = CH_LINE_FEED;
        end else if (pick < 70) begin
          cmd.char_code = CH_CARRIAGE;
        end else if (pick < 77) begin
          cmd.char_code = CH_BACKSPACE;
        end else if (pick < 82) begin
          cmd.char_code = 8'($urandom_range(127, 255));
        end else if (pick < 85) begin
          cmd.char_code = 8'($urandom_range(0, 31));
        end else if (pick < 94) begin
          cmd.opcode = OP_SET_POS;
          if ($urandom_range(99) < 70) begin
            cmd.new_column = 8'($urandom_range(0, eff_count(cfg_cols)));
            cmd.new_row    = 8'($urandom_range(0, eff_count(cfg_rows)));
          end
        end else if (pick < 97) begin
          cmd.opcode = OP_CLEAR;
        end else begin
          cmd.opcode = opcode_e'(OP_UNUSED);
        end
        send_cmd(cmd, 1'b0, '0);
      end
      idle_on = 1'b1;
    end

    wait_idle();
    repeat (6) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_step.sv
rtl/tcce_outq.sv
rtl/text_console_cursor_engine.sv
rtl/tcce_checker.sv
test/text_console_cursor_engine_tb.sv
